// File: rtl/core/sbs_pkg.sv
`default_nettype none

package sbs_pkg;

  localparam int TABLE_DEPTH = 32;

  // Cell address width and the width of a count that can hold the depth itself.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the words on the ports.
  localparam int ENTRY_W = 5;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 6;

  // Width used when a cell compares a write address with its own address.
  localparam int ID_CMP_W = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // One word travelling down the cell chain, with the compare bits that the
  // cells it has passed have filled in.
  typedef struct packed {
    logic                     valid;
    logic                     req_type;
    logic [ENTRY_W-1:0]       idx;
    logic signed [VALUE_W-1:0] value;
    logic [TABLE_DEPTH-1:0]   eq;
    logic [TABLE_DEPTH-1:0]   lt;
  } stage_t;

endpackage

`default_nettype wire

// File: rtl/core/sbs_cell.sv
`default_nettype none

module sbs_cell
  import sbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [IDX_W-1:0] cell_id,
  input  wire stage_t           stage_in,
  output stage_t                stage_out
);

  logic signed [VALUE_W-1:0] entry_r;
  stage_t                    stage_r;
  stage_t                    stage_nxt;
  logic                      hit_write;

  assign hit_write = stage_in.valid && (stage_in.req_type == REQ_WRITE) &&
                     (ID_CMP_W'(stage_in.idx) == ID_CMP_W'(cell_id));

  // A search picks up this cell's equal and less-than bits as it passes. Any
  // write ahead of it has already gone by, so the entry is current.
  always_comb begin
    stage_nxt = stage_in;
    if (stage_in.valid && (stage_in.req_type == REQ_SEARCH)) begin
      stage_nxt.eq[cell_id] = (stage_in.value == entry_r);
      stage_nxt.lt[cell_id] = (stage_in.value < entry_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_write) begin
      entry_r <= stage_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

// File: rtl/core/sbs_search.sv
`default_nettype none

module sbs_search
  import sbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stage_t           tail,
  input  wire logic [CNT_W-1:0] size_lim,
  output logic                  adv,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_found
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic [TABLE_DEPTH-1:0] eq_r, lt_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;

  logic                   tail_search;
  logic                   take_search;
  logic                   out_free;
  logic                   finish;
  logic                   result;
  logic [CNT_W:0]         mid_sum;
  logic [IDX_W-1:0]       mid;

  assign tail_search = tail.valid && (tail.req_type == REQ_SEARCH);
  // The chain stops only when a search at its tail finds the probe loop busy.
  assign adv         = !(tail_search && (state_r == ST_PROBE));
  assign take_search = tail_search && adv;
  assign out_free    = !out_valid_r || !out_stall;

  // Interval is [lo, hi) so it never goes negative; mid = (lo + hi - 1) / 2.
  assign mid_sum = (CNT_W + 1)'(lo_r) + (CNT_W + 1)'(hi_r) - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    finish        = 1'b0;
    result        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (take_search) begin
          lo_nxt    = '0;
          hi_nxt    = size_lim;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_r >= hi_r) begin
          finish = 1'b1;
          result = 1'b0;
        end else if (eq_r[mid]) begin
          finish = 1'b1;
          result = 1'b1;
        end else if (lt_r[mid]) begin
          hi_nxt = CNT_W'(mid);
        end else begin
          lo_nxt = CNT_W'(mid) + CNT_W'(1);
        end
        // A finished search waits here until the output register is free.
        if (finish) begin
          lo_nxt = lo_r;
          hi_nxt = hi_r;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = result;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_found_r <= out_found_nxt;
    if (take_search) begin
      eq_r <= tail.eq;
      lt_r <= tail.lt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  a_take_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take_search |-> state_r == ST_IDLE)
    else $error("search loaded while the probe loop is busy");

  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> (lo_r <= hi_r) && (int'(hi_r) <= TABLE_DEPTH))
    else $error("probe interval out of order or beyond the table");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) && finish && out_free |=> state_r == ST_IDLE && out_valid_r)
    else $error("finished search did not reach the output register");

  a_hold_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) && finish && !out_free |=> state_r == ST_PROBE &&
      $stable(lo_r) && $stable(hi_r))
    else $error("blocked result lost its interval");

endmodule

`default_nettype wire

// File: rtl/core/sorted_table_binary_search_top.sv
`default_nettype none

// Searches a table of TABLE_DEPTH signed 32-bit entries that software loads in
// ascending order, one entry per write word; table_size selects how many of the
// first entries a search considers (values above the depth count as the depth).
// Every word, write or search, moves down a chain of TABLE_DEPTH cells, one cell
// per cycle unless the chain stops; each cell holds one entry and adds its equal
// and less-than bits to a passing search, so words keep their order and a search
// sees every earlier write. At the end of the chain a probe loop walks the binary
// search over those bits, one probe per cycle. A search is loaded into the loop
// only while it is idle; the chain stops while a search at its tail waits for a
// busy loop, and the loop stays busy while the result side stalls. Writes flow at
// one per cycle unless the chain stops. A word passes the TABLE_DEPTH cell
// registers; a search then goes through the probe loop to the output register. A
// write gives no result word; a search gives one, with found set if a probe
// matched. Reading an entry never written since reset gives an undefined answer.
module sorted_table_binary_search_top
  import sbs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [SIZE_W-1:0]         cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_req_type,
  input  wire logic [ENTRY_W-1:0]        in_entry_index,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_found
);

  logic [SIZE_W-1:0] table_size_r;
  logic [CNT_W-1:0]  size_lim;
  logic              adv;
  stage_t            stage [TABLE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(table_size_r) > TABLE_DEPTH) begin
      size_lim = CNT_W'(TABLE_DEPTH);
    end else begin
      size_lim = CNT_W'(table_size_r);
    end
  end

  always_comb begin
    stage[0]          = '0;
    stage[0].valid    = in_valid;
    stage[0].req_type = in_req_type;
    stage[0].idx      = in_entry_index;
    stage[0].value    = in_value;
  end

  assign in_stall = !adv;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sbs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cell_id   (IDX_W'(i)),
      .stage_in  (stage[i]),
      .stage_out (stage[i+1])
    );
  end

  sbs_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail      (stage[TABLE_DEPTH]),
    .size_lim  (size_lim),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_found (out_found)
  );

endmodule

`default_nettype wire
